@@ rtl/core/dep_pkg.sv @@
`timescale 1ns / 1ps

package dep_pkg;

    // Build-time defaults and fixed field widths.
    localparam int DEFAULT_CHANNELS = 8;
    localparam int PIN_WIDTH        = 8;
    localparam int CNT_WIDTH        = 8;
    localparam int PULSE_WIDTH      = 9;
    localparam int ADDR_WIDTH       = 4;
    localparam int DATA_WIDTH       = 32;

    localparam logic [PULSE_WIDTH-1:0] PULSE_SAT = 9'd511;

    // Register reset values.
    localparam logic [7:0] RST_DEBOUNCE_COUNT  = 8'd3;
    localparam logic [2:0] RST_COIL_CHANNEL    = 3'd0;
    localparam logic [2:0] RST_BARRIER_CHANNEL = 3'd0;
    localparam logic [7:0] RST_PULSE_TICKS     = 8'd30;

    // Register indexes (word address).
    typedef enum logic [1:0] {
        REG_DEBOUNCE_COUNT  = 2'd0,
        REG_COIL_CHANNEL    = 2'd1,
        REG_BARRIER_CHANNEL = 2'd2,
        REG_PULSE_TICKS     = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [7:0] debounce_count;
        logic [2:0] coil_channel;
        logic [2:0] barrier_channel;
        logic [7:0] pulse_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] raw_inputs;
        logic       space_available;
    } t_in_item;

    typedef struct packed {
        logic [7:0] filtered_levels;
        logic [7:0] output_byte;
        logic       output_write;
        logic       coil_entered;
        logic       coil_left;
    } t_out_item;

    // Debounced levels before and after the current tick, padded to the pin width.
    typedef struct packed {
        logic [PIN_WIDTH-1:0] old_levels;
        logic [PIN_WIDTH-1:0] new_levels;
    } t_levels;

    typedef struct packed {
        logic [7:0] output_byte;
        logic       output_write;
        logic       coil_entered;
        logic       coil_left;
    } t_pulse_res;

endpackage

@@ rtl/core/dep_cfg_regs.sv @@
`timescale 1ns / 1ps

module dep_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dep_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [dep_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [dep_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready,
    output dep_pkg::t_cfg                     o_cfg
);
    import dep_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[3:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_count  <= RST_DEBOUNCE_COUNT;
            r_cfg.coil_channel    <= RST_COIL_CHANNEL;
            r_cfg.barrier_channel <= RST_BARRIER_CHANNEL;
            r_cfg.pulse_ticks     <= RST_PULSE_TICKS;
        end else if (w_write) begin
            unique case (w_index)
                REG_DEBOUNCE_COUNT:  r_cfg.debounce_count  <= pwdata[7:0];
                REG_COIL_CHANNEL:    r_cfg.coil_channel    <= pwdata[2:0];
                REG_BARRIER_CHANNEL: r_cfg.barrier_channel <= pwdata[2:0];
                REG_PULSE_TICKS:     r_cfg.pulse_ticks     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (w_index)
            REG_DEBOUNCE_COUNT:  prdata = {24'd0, r_cfg.debounce_count};
            REG_COIL_CHANNEL:    prdata = {29'd0, r_cfg.coil_channel};
            REG_BARRIER_CHANNEL: prdata = {29'd0, r_cfg.barrier_channel};
            REG_PULSE_TICKS:     prdata = {24'd0, r_cfg.pulse_ticks};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/dep_debounce.sv @@
`timescale 1ns / 1ps

module dep_debounce #(
    parameter int CHANNELS = dep_pkg::DEFAULT_CHANNELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [dep_pkg::PIN_WIDTH-1:0]  i_active,
    input  logic [dep_pkg::CNT_WIDTH-1:0]  i_debounce_count,
    output dep_pkg::t_levels               o_levels
);
    import dep_pkg::*;

    logic [CHANNELS-1:0] w_acc_old;
    logic [CHANNELS-1:0] w_acc_new;

    // One counter debounce lane per channel.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        logic                 r_acc;
        logic [CNT_WIDTH-1:0] r_cnt;
        logic                 w_sample;
        logic [CNT_WIDTH-1:0] w_inc;
        logic                 n_acc;
        logic [CNT_WIDTH-1:0] n_cnt;

        if (i < PIN_WIDTH) begin : g_pin
            assign w_sample = i_active[i];
        end else begin : g_nopin
            assign w_sample = 1'b0;
        end

        assign w_inc = r_cnt + CNT_WIDTH'(1);

        // A differing sample counts up; reaching the threshold accepts it.
        always_comb begin
            n_acc = r_acc;
            n_cnt = '0;
            if (w_sample != r_acc) begin
                if (w_inc >= i_debounce_count) begin
                    n_acc = w_sample;
                end else begin
                    n_cnt = w_inc;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc <= 1'b0;
                r_cnt <= '0;
            end else if (i_advance) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
        end

        assign w_acc_old[i] = r_acc;
        assign w_acc_new[i] = n_acc;
    end

    // Pad to the pin width; missing channels read as inactive.
    for (genvar k = 0; k < PIN_WIDTH; k++) begin : g_pad
        if (k < CHANNELS) begin : g_have
            assign o_levels.old_levels[k] = w_acc_old[k];
            assign o_levels.new_levels[k] = w_acc_new[k];
        end else begin : g_none
            assign o_levels.old_levels[k] = 1'b0;
            assign o_levels.new_levels[k] = 1'b0;
        end
    end

endmodule

@@ rtl/core/dep_pulse.sv @@
`timescale 1ns / 1ps

module dep_pulse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_space,
    input  dep_pkg::t_levels   i_levels,
    input  dep_pkg::t_cfg      i_cfg,
    output dep_pkg::t_pulse_res o_result
);
    import dep_pkg::*;

    logic [PULSE_WIDTH-1:0] r_counter;
    logic [7:0]             r_out_reg;
    logic [7:0]             r_last;
    logic [PULSE_WIDTH-1:0] n_counter;
    logic [7:0]             n_out_reg;
    logic [PULSE_WIDTH-1:0] w_inc;
    logic [PULSE_WIDTH-1:0] w_release;
    logic [7:0]             w_mask;
    logic                   w_prev;
    logic                   w_cur;

    // Coil edge detection on the debounced levels.
    assign w_prev    = i_levels.old_levels[i_cfg.coil_channel];
    assign w_cur     = i_levels.new_levels[i_cfg.coil_channel];
    assign w_mask    = 8'd1 << i_cfg.barrier_channel;
    assign w_inc     = (r_counter == PULSE_SAT) ? r_counter : r_counter + PULSE_WIDTH'(1);
    assign w_release = {1'b0, i_cfg.pulse_ticks} + PULSE_WIDTH'(1);

    // Barrier pulse: set on entry, released after the hold count or on exit.
    always_comb begin
        n_counter = r_counter;
        n_out_reg = r_out_reg;
        priority if (!w_prev && w_cur && i_space) begin
            n_counter = '0;
            n_out_reg = r_out_reg | w_mask;
        end else if (w_prev && w_cur && i_space) begin
            n_counter = w_inc;
            if (w_inc == w_release) begin
                n_out_reg = r_out_reg & ~w_mask;
            end
        end else if (w_prev && !w_cur && i_space) begin
            n_counter = '0;
            n_out_reg = r_out_reg & ~w_mask;
        end else begin
            n_counter = r_counter;
        end
    end

    assign o_result.output_byte  = n_out_reg;
    assign o_result.output_write = n_out_reg != r_last;
    assign o_result.coil_entered = !w_prev && w_cur;
    assign o_result.coil_left    = w_prev && !w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_out_reg <= '0;
            r_last    <= '0;
        end else if (i_advance) begin
            r_counter <= n_counter;
            r_out_reg <= n_out_reg;
            r_last    <= n_out_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // An edge is either rising or falling, never both.
    a_edge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> !(o_result.coil_entered && o_result.coil_left))
        else $error("coil edge reported as rising and falling");

    // Without space the output register must not move.
    a_no_space_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_space) |=> (r_out_reg == $past(r_out_reg)))
        else $error("output register changed without space");

    // A saturated counter either stays or restarts from zero.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_counter == PULSE_SAT) |=>
        (r_counter == PULSE_SAT || r_counter == '0))
        else $error("pulse counter left saturation");

    // Pulse state holds while no beat advances.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_counter) && $stable(r_out_reg) && $stable(r_last)))
        else $error("pulse state changed without a beat");
`endif

endmodule

@@ rtl/core/debounce_edge_pulse_output.sv @@
`timescale 1ns / 1ps
// An accepted beat goes through the input register, then the result register.
// Throughput: one beat per cycle; the input register takes a new beat whenever
// the result register is empty or being drained in the same cycle.
// Reset (synchronous, active low) clears all debounce, pulse and valid state
// and loads the register defaults: debounce 3, channels 0, pulse ticks 30.

module debounce_edge_pulse_output #(
    parameter int CHANNELS = dep_pkg::DEFAULT_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dep_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dep_pkg::t_out_item              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dep_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [dep_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [dep_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import dep_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_data;
    logic       r_out_valid;
    t_out_item  r_out_data;
    logic       w_advance;
    t_cfg       w_cfg;
    t_levels    w_levels;
    t_pulse_res w_pulse;

    // Handshake: the stored beat moves on when the result register is free.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    dep_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dep_debounce #(
        .CHANNELS (CHANNELS)
    ) u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_active         (~r_in_data.raw_inputs),
        .i_debounce_count (w_cfg.debounce_count),
        .o_levels         (w_levels)
    );

    dep_pulse u_pulse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_space  (r_in_data.space_available),
        .i_levels (w_levels),
        .i_cfg    (w_cfg),
        .o_result (w_pulse)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data.filtered_levels <= w_levels.new_levels;
            r_out_data.output_byte     <= w_pulse.output_byte;
            r_out_data.output_write    <= w_pulse.output_write;
            r_out_data.coil_entered    <= w_pulse.coil_entered;
            r_out_data.coil_left       <= w_pulse.coil_left;
        end
    end

endmodule

@@ tb/sv/debounce_pulse_checker.sv @@
`timescale 1ns / 1ps

module debounce_pulse_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  dep_pkg::t_in_item               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  dep_pkg::t_out_item              i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [dep_pkg::ADDR_WIDTH-1:0]  i_paddr,
    input  logic [dep_pkg::DATA_WIDTH-1:0]  i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_writes,
    output int                              o_edges
);
    import dep_pkg::*;

    localparam int SHOW_LIMIT = 10;

    // Shadow of the register file and of the block's scan state.
    t_cfg        cfg_shadow;
    logic [7:0]  db_count [8];
    logic [7:0]  levels;
    logic [8:0]  pulse_count;
    logic [7:0]  out_reg;
    logic [7:0]  out_written;

    // Results predicted for accepted ticks, oldest first.
    t_out_item   expected_ticks [$];
    t_out_item   oldest;
    t_reg_index  reg_sel;
    int          shown = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_writes     = 0;
        o_edges      = 0;
    end

    // Advances the shadow state by one scan tick and returns its result beat.
    function automatic t_out_item next_tick_result(input t_in_item beat);
        logic [7:0] active;
        logic [7:0] prev;
        logic       was_on;
        logic       now_on;
        t_out_item  res;
        active = ~beat.raw_inputs;
        prev   = levels;
        res    = '0;
        for (int ch = 0; ch < 8; ch++) begin
            if (active[ch] != levels[ch]) begin
                db_count[ch] = db_count[ch] + 8'd1;
                if (db_count[ch] >= cfg_shadow.debounce_count) begin
                    db_count[ch] = 8'd0;
                    levels[ch]   = active[ch];
                end
            end else begin
                db_count[ch] = 8'd0;
            end
        end

        // Coil edges drive the barrier bit; without space only edges are flagged.
        was_on = prev[cfg_shadow.coil_channel];
        now_on = levels[cfg_shadow.coil_channel];
        if (!was_on && now_on) begin
            res.coil_entered = 1'b1;
            if (beat.space_available) begin
                pulse_count = 9'd0;
                out_reg[cfg_shadow.barrier_channel] = 1'b1;
            end
        end else if (was_on && now_on) begin
            if (beat.space_available) begin
                if (pulse_count < PULSE_SAT) begin
                    pulse_count = pulse_count + 9'd1;
                end
                if (pulse_count == {1'b0, cfg_shadow.pulse_ticks} + 9'd1) begin
                    out_reg[cfg_shadow.barrier_channel] = 1'b0;
                end
            end
        end else if (was_on && !now_on) begin
            res.coil_left = 1'b1;
            if (beat.space_available) begin
                pulse_count = 9'd0;
                out_reg[cfg_shadow.barrier_channel] = 1'b0;
            end
        end

        res.output_write = (out_reg != out_written);
        if (res.output_write) begin
            out_written = out_reg;
        end
        res.filtered_levels = levels;
        res.output_byte     = out_reg;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            o_fail_count = o_fail_count + 1;
            if (shown < SHOW_LIMIT) begin
                shown = shown + 1;
                $display("Result beat %0d, %s: expected 0x%0h, got 0x%0h",
                         o_results, field, want, got);
            end
        end
    endtask

    // Track register writes, predict on input beats, compare on result beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow.debounce_count  = RST_DEBOUNCE_COUNT;
            cfg_shadow.coil_channel    = RST_COIL_CHANNEL;
            cfg_shadow.barrier_channel = RST_BARRIER_CHANNEL;
            cfg_shadow.pulse_ticks     = RST_PULSE_TICKS;
            for (int ch = 0; ch < 8; ch++) begin
                db_count[ch] = 8'd0;
            end
            levels      = 8'd0;
            pulse_count = 9'd0;
            out_reg     = 8'd0;
            out_written = 8'd0;
            expected_ticks.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_sel = t_reg_index'(i_paddr[3:2]);
                case (reg_sel)
                    REG_DEBOUNCE_COUNT:  cfg_shadow.debounce_count  = i_pwdata[7:0];
                    REG_COIL_CHANNEL:    cfg_shadow.coil_channel    = i_pwdata[2:0];
                    REG_BARRIER_CHANNEL: cfg_shadow.barrier_channel = i_pwdata[2:0];
                    REG_PULSE_TICKS:     cfg_shadow.pulse_ticks     = i_pwdata[7:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                oldest = next_tick_result(i_in_data);
                expected_ticks.push_back(oldest);
                o_writes = o_writes + oldest.output_write;
                o_edges  = o_edges + oldest.coil_entered + oldest.coil_left;
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (shown < SHOW_LIMIT) begin
                        shown = shown + 1;
                        $display("Result beat %0d arrived with nothing expected: 0x%0h",
                                 o_results, i_out_data);
                    end
                end else begin
                    oldest = expected_ticks.pop_front();
                    check_field("filtered_levels", oldest.filtered_levels,
                                i_out_data.filtered_levels);
                    check_field("output_byte", oldest.output_byte,
                                i_out_data.output_byte);
                    check_field("output_write", 8'(oldest.output_write),
                                8'(i_out_data.output_write));
                    check_field("coil_entered", 8'(oldest.coil_entered),
                                8'(i_out_data.coil_entered));
                    check_field("coil_left", 8'(oldest.coil_left),
                                8'(i_out_data.coil_left));
                end
                o_results = o_results + 1;
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dep_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_ready;
    t_out_item               o_out_data;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_WIDTH-1:0]   paddr;
    logic [DATA_WIDTH-1:0]   pwdata;
    logic [DATA_WIDTH-1:0]   prdata;
    logic                    pready;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          write_strobes;
    int          coil_edges;

    int          beats_sent = 0;
    int          burst_left = 0;
    int          settings_used = 1;
    int          quiet_cycles = 0;
    logic [2:0]  coil_sel = RST_COIL_CHANNEL;

    t_rx_mode    rx_mode;
    int          rx_left;
    int          rx_phase;

    debounce_edge_pulse_output dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    debounce_pulse_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_writes     (write_strobes),
        .o_edges      (coil_edges)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The result side stalls on a pattern that changes mode every so often.
    initial begin
        i_out_ready = 1'b0;
        rx_mode     = RX_OPEN;
        rx_left     = 0;
        rx_phase    = 0;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE: i_out_ready <= (rx_phase % 4 == 0);
            RX_BURSTY: i_out_ready <= (rx_phase % 16 >= 12);
            default:   i_out_ready <= 1'b1;
        endcase
    end

    // Ends the run when no beat has moved on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one scan tick and holds it until accepted; opens a gap between bursts.
    task automatic push_tick(input logic [7:0] raw, input logic space);
        t_in_item beat;
        int       gap;
        beat.raw_inputs      = raw;
        beat.space_available = space;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent = beats_sent + 1;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left = burst_left - 1;
        end
    endtask

    task automatic hold_level(input logic [7:0] raw, input logic space, input int n);
        repeat (n) push_tick(raw, space);
    endtask

    // Stops sending until every predicted result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_index idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] deb, input logic [2:0] coil,
                                  input logic [2:0] barrier, input logic [7:0] pulse);
        settle();
        cfg_write(REG_DEBOUNCE_COUNT, 32'(deb));
        cfg_write(REG_COIL_CHANNEL, 32'(coil));
        cfg_write(REG_BARRIER_CHANNEL, 32'(barrier));
        cfg_write(REG_PULSE_TICKS, 32'(pulse));
        coil_sel = coil;
        settings_used = settings_used + 1;
    endtask

    // Mostly held levels with the coil toggling between holds, plus glitches
    // and stretches of pure noise.
    task automatic run_random(input int n, input int min_hold, input int max_hold);
        int          done;
        int          hold;
        int          pin;
        logic [7:0]  base;
        logic [7:0]  raw;
        logic        coil_on;
        logic        space;
        done    = 0;
        coil_on = 1'b0;
        while (done < n) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 9) < 6) begin
                    coil_on = !coil_on;
                end
                base = 8'($urandom_range(0, 255));
                base[coil_sel] = !coil_on;
                hold  = $urandom_range(min_hold, max_hold);
                space = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < hold && done < n; k++) begin
                    raw = base;
                    if ($urandom_range(0, 19) == 0) begin
                        pin = $urandom_range(0, 7);
                        raw[pin] = !raw[pin];
                    end
                    if ($urandom_range(0, 31) == 0) begin
                        space = !space;
                    end
                    push_tick(raw, space);
                    done = done + 1;
                end
            end else begin
                hold = $urandom_range(1, 8);
                for (int k = 0; k < hold && done < n; k++) begin
                    push_tick(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    done = done + 1;
                end
            end
            if ($urandom_range(0, 29) == 0) begin
                settle();
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all channels on and off, edges with and without space.
        hold_level(8'hFF, 1'b1, 2);
        hold_level(8'h00, 1'b1, 3);
        hold_level(8'h00, 1'b0, 1);
        hold_level(8'h00, 1'b1, 2);
        hold_level(8'hFF, 1'b0, 3);
        hold_level(8'h00, 1'b0, 3);
        hold_level(8'hFF, 1'b1, 3);
        push_tick(8'hAA, 1'b1);
        push_tick(8'h55, 1'b1);

        // Zero debounce count, top channels, release on the first counted tick.
        apply_settings(8'd0, 3'd7, 3'd7, 8'd0);
        hold_level(8'h7F, 1'b1, 3);
        push_tick(8'hFF, 1'b1);
        push_tick(8'h7F, 1'b0);
        push_tick(8'hFF, 1'b0);
        push_tick(8'h00, 1'b1);

        apply_settings(8'd1, 3'd3, 3'd5, 8'd4);
        run_random(250, 1, 12);

        // Longest pulse.
        apply_settings(8'd2, 3'd0, 3'd0, 8'd255);
        run_random(360, 200, 300);

        // Longest debounce.
        apply_settings(8'd255, 3'd7, 3'd2, 8'd10);
        run_random(520, 260, 290);

        // Pulse length changed while the coil is held, then the counter runs
        // past the release point into saturation.
        apply_settings(8'd1, 3'd2, 3'd2, 8'd50);
        hold_level(8'hFB, 1'b1, 20);
        settle();
        cfg_write(REG_PULSE_TICKS, 32'd5);
        hold_level(8'hFB, 1'b1, 20);
        settle();
        cfg_write(REG_PULSE_TICKS, 32'd255);
        hold_level(8'hFB, 1'b1, 500);
        hold_level(8'hFF, 1'b1, 5);
        run_random(60, 1, 10);

        repeat (3) begin
            apply_settings(8'($urandom_range(0, 6)), 3'($urandom_range(0, 7)),
                           3'($urandom_range(0, 7)), 8'($urandom_range(0, 20)));
            run_random(60, 1, 30);
        end

        settle();
        $display("Sent %0d scan ticks and checked %0d result beats under %0d register settings,",
                 beats_sent, results_seen, settings_used);
        $display("with %0d output write strobes and %0d coil edges predicted.",
                 write_strobes, coil_edges);
        if (pending != 0) begin
            $display("%0d expected result beats never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
